FILE: rtl/core/chd_pkg.sv
package chd_pkg;

    localparam int SIZE_WIDTH_DEF = 32;

    // Decoder phases
    localparam logic [2:0] PH_SIZE = 3'd0;
    localparam logic [2:0] PH_DATA = 3'd1;
    localparam logic [2:0] PH_SKIP = 3'd2;
    localparam logic [2:0] PH_DONE = 3'd3;
    localparam logic [2:0] PH_ERR  = 3'd4;

    // Error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_HEX   = 2'd1;
    localparam logic [1:0] ERR_EMPTY = 2'd2;
    localparam logic [1:0] ERR_OVF   = 2'd3;

    // Characters of the size line
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    // Bytes dropped after the chunk data, and bits per hex digit
    localparam logic [1:0] SKIP_LEN   = 2'd2;
    localparam int         HEX_BITS   = 4;

    typedef struct packed {
        logic [2:0] phase;
        logic       digit_seen;
        logic       in_ext;
        logic       cr_pending;
        logic [1:0] skip_cnt;
        logic [1:0] err;
    } ctl_t;

    localparam ctl_t CTL_RESET = '{
        phase:      PH_SIZE,
        digit_seen: 1'b0,
        in_ext:     1'b0,
        cr_pending: 1'b0,
        skip_cnt:   2'd0,
        err:        ERR_NONE
    };

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       chunk_last;
        logic       body_done;
        logic [1:0] decode_error;
    } result_t;

    // Returns {is_hex, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/chd_parser.sv
module chd_parser
    import chd_pkg::*;
#(
    parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
)
(
    input  logic [7:0]            body_byte,
    input  logic                  body_start,
    input  ctl_t                  ctl_cur,
    input  logic [SIZE_WIDTH-1:0] acc_cur,
    input  logic [SIZE_WIDTH-1:0] rem_cur,
    output ctl_t                  ctl_new,
    output logic [SIZE_WIDTH-1:0] acc_new,
    output logic [SIZE_WIDTH-1:0] rem_new,
    output result_t               res
);

    always_comb
    begin
        ctl_t                  c;
        logic [SIZE_WIDTH-1:0] acc;
        logic [SIZE_WIDTH-1:0] rem;
        logic                  take_char;
        logic [4:0]            hx;
        logic                  pvalid;
        logic                  plast;

        // A start byte begins from the reset state
        c         = body_start ? CTL_RESET : ctl_cur;
        acc       = body_start ? '0 : acc_cur;
        rem       = body_start ? '0 : rem_cur;
        take_char = 1'b0;
        pvalid    = 1'b0;
        plast     = 1'b0;
        hx        = hex_decode(body_byte);

        case (c.phase)
            PH_SIZE:
            begin
                take_char = 1'b1;
                if (c.cr_pending)
                begin
                    c.cr_pending = 1'b0;
                    if (body_byte == CH_LF)
                    begin
                        take_char = 1'b0;
                        if (!c.digit_seen)
                        begin
                            c.err   = ERR_EMPTY;
                            c.phase = PH_ERR;
                        end
                        else if (acc == '0)
                        begin
                            c.phase = PH_DONE;
                        end
                        else
                        begin
                            rem     = acc;
                            c.phase = PH_DATA;
                        end
                    end
                    else if (!c.in_ext)
                    begin
                        // lone CR before the cut
                        take_char = 1'b0;
                        c.err     = ERR_HEX;
                        c.phase   = PH_ERR;
                    end
                end
                if (take_char)
                begin
                    if (body_byte == CH_CR)
                    begin
                        c.cr_pending = 1'b1;
                    end
                    else if (!c.in_ext)
                    begin
                        if (body_byte == CH_SEMI || body_byte == CH_SPACE
                            || body_byte == CH_TAB)
                        begin
                            c.in_ext = 1'b1;
                        end
                        else if (!hx[4])
                        begin
                            c.err   = ERR_HEX;
                            c.phase = PH_ERR;
                        end
                        else if (acc[SIZE_WIDTH-1 -: HEX_BITS] != '0)
                        begin
                            c.err   = ERR_OVF;
                            c.phase = PH_ERR;
                        end
                        else
                        begin
                            acc          = {acc[SIZE_WIDTH-HEX_BITS-1:0], hx[3:0]};
                            c.digit_seen = 1'b1;
                        end
                    end
                end
            end
            PH_DATA:
            begin
                pvalid = 1'b1;
                rem    = rem - {{(SIZE_WIDTH-1){1'b0}}, 1'b1};
                if (rem == '0)
                begin
                    plast      = 1'b1;
                    c.phase    = PH_SKIP;
                    c.skip_cnt = SKIP_LEN;
                end
            end
            PH_SKIP:
            begin
                c.skip_cnt = c.skip_cnt - 2'd1;
                if (c.skip_cnt == 2'd0)
                begin
                    c.phase      = PH_SIZE;
                    c.digit_seen = 1'b0;
                    c.in_ext     = 1'b0;
                    c.cr_pending = 1'b0;
                    acc          = '0;
                end
            end
            default:
            begin
                // done or error: drop the byte
            end
        endcase

        ctl_new = c;
        acc_new = acc;
        rem_new = rem;

        res.payload_byte  = pvalid ? body_byte : 8'd0;
        res.payload_valid = pvalid;
        res.chunk_last    = plast;
        res.body_done     = (c.phase == PH_DONE);
        res.decode_error  = c.err;
    end

endmodule

FILE: rtl/core/chd_out_stage.sv
module chd_out_stage
    import chd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res_in,
    input  logic    out_stall,
    output logic    take,
    output logic    out_valid,
    output result_t res_out
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // The register can take a new result when empty or being drained
    assign take = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && load)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

FILE: rtl/core/http_chunked_body_decoder_top.sv
// Chunked body decoder: strips HTTP/1.1 chunk framing from a byte stream.
//
// Input channel: body_byte/body_start with in_valid/in_stall. One transfer
// carries one raw body byte; body_start marks the first byte of a new body
// and restarts the decoder before that byte is looked at.
// Output channel: payload_byte, payload_valid, chunk_last, body_done and
// decode_error with out_valid/out_stall. Every input transfer yields exactly
// one output transfer, in order; payload_valid marks chunk data bytes.
// body_done and decode_error stick until the next body_start.
//
// The byte lands in the input register, then one pass of parser logic
// updates the decoder state and fills the result register. Throughput is
// one byte per cycle while the receiver does not stall.
// Reset clears the decoder to the start of a size line and empties both
// register stages. When the receiver stalls, the result register holds, the
// input register holds its byte, and in_stall rises once it is full.
module http_chunked_body_decoder_top
    import chd_pkg::*;
#(
    parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] body_byte,
    input  logic       body_start,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] payload_byte,
    output logic       payload_valid,
    output logic       chunk_last,
    output logic       body_done,
    output logic [1:0] decode_error
);

    // Input register
    logic       in_full_reg;
    logic       in_full_next;
    logic [7:0] byte_reg;
    logic       start_reg;

    // Decoder state
    ctl_t                  ctl_reg;
    logic [SIZE_WIDTH-1:0] acc_reg;
    logic [SIZE_WIDTH-1:0] rem_reg;
    ctl_t                  ctl_next;
    logic [SIZE_WIDTH-1:0] acc_next;
    logic [SIZE_WIDTH-1:0] rem_next;

    result_t res_comb;
    result_t res_q;
    logic    out_take;
    logic    advance;
    logic    in_accept;

    // Advance the held byte into the result register when it can take it
    assign advance   = in_full_reg && out_take;
    assign in_stall  = in_full_reg && !out_take;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        in_full_next = in_full_reg;
        if (in_accept)
        begin
            in_full_next = 1'b1;
        end
        else if (advance)
        begin
            in_full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
            ctl_reg     <= CTL_RESET;
            acc_reg     <= '0;
            rem_reg     <= '0;
        end
        else
        begin
            in_full_reg <= in_full_next;
            if (advance)
            begin
                ctl_reg <= ctl_next;
                acc_reg <= acc_next;
                rem_reg <= rem_next;
            end
        end
    end

    // Payload of the input register needs no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            byte_reg  <= body_byte;
            start_reg <= body_start;
        end
    end

    chd_parser #(
        .SIZE_WIDTH (SIZE_WIDTH)
    ) u_parser (
        .body_byte  (byte_reg),
        .body_start (start_reg),
        .ctl_cur    (ctl_reg),
        .acc_cur    (acc_reg),
        .rem_cur    (rem_reg),
        .ctl_new    (ctl_next),
        .acc_new    (acc_next),
        .rem_new    (rem_next),
        .res        (res_comb)
    );

    chd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_full_reg),
        .res_in    (res_comb),
        .out_stall (out_stall),
        .take      (out_take),
        .out_valid (out_valid),
        .res_out   (res_q)
    );

    assign payload_byte  = res_q.payload_byte;
    assign payload_valid = res_q.payload_valid;
    assign chunk_last    = res_q.chunk_last;
    assign body_done     = res_q.body_done;
    assign decode_error  = res_q.decode_error;

endmodule

FILE: rtl/core/chd_checker.sv
module chd_checker
    import chd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       payload_valid,
    input logic       chunk_last,
    input logic       body_done,
    input logic [1:0] decode_error
);

    // A stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // Only a data byte can close a chunk
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && chunk_last |-> payload_valid)
        else $error("chunk_last without payload");

    // End of body and an error never show together
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && body_done |-> decode_error == ERR_NONE)
        else $error("body_done with error");

    // Data bytes pass only while the body is still open and clean
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && payload_valid |-> !body_done && decode_error == ERR_NONE)
        else $error("payload after end or error");

endmodule

bind http_chunked_body_decoder_top chd_checker u_chd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .payload_valid (payload_valid),
    .chunk_last    (chunk_last),
    .body_done     (body_done),
    .decode_error  (decode_error)
);

FILE: sim/http_chunked_body_decoder_top_tb.sv
module http_chunked_body_decoder_top_tb;
    import chd_pkg::*;

    localparam int SIZE_W       = SIZE_WIDTH_DEF;
    localparam int RANDOM_GOAL  = 1650;
    localparam int PHASE_COUNT  = 4;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 40;

    // Hex digit boundaries for building and classifying size lines
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_F = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;

    // One input transfer: raw body byte plus the new-body marker
    typedef struct packed {
        logic [7:0] raw;
        logic       start;
    } body_xfer_t;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic [7:0] body_byte  = 8'h00;
    logic       body_start = 1'b0;
    logic       out_stall  = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       chunk_last;
    logic       body_done;
    logic [1:0] decode_error;

    http_chunked_body_decoder_top i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .body_byte     (body_byte),
        .body_start    (body_start),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .payload_byte  (payload_byte),
        .payload_valid (payload_valid),
        .chunk_last    (chunk_last),
        .body_done     (body_done),
        .decode_error  (decode_error)
    );

    // Bytes waiting to be sent, bytes the block took, results it gave,
    // and the decoded results still owed by the block.
    body_xfer_t body_stream_q[$];
    body_xfer_t taken_bytes_q[$];
    result_t    seen_out_q[$];
    result_t    decoded_q[$];

    int         items_queued    = 0;
    int         junk_queued     = 0;
    int         results_checked = 0;
    int         fail_cnt        = 0;
    int         src_idle_pct    = 0;
    int         snk_stall_pct   = 0;
    logic [7:0] cyc_cnt         = '0;
    bit         next_start      = 1'b0;
    wire        calm            = (cyc_cnt[7:5] == 3'd0);

    // Decoder state as this bench tracks it
    logic [2:0]        dec_phase;
    logic [SIZE_W-1:0] size_acc;
    logic [SIZE_W-1:0] data_left;
    logic [1:0]        skip_left;
    logic [1:0]        err_code;
    bit                digit_seen;
    bit                in_ext;
    bit                cr_pend;

    // ------------------------------------------------------------------
    // Decoder prediction
    // ------------------------------------------------------------------

    function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
        v = 4'd0;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            v = 4'(c - CH_ZERO);
            return 1'b1;
        end
        if (c >= CH_LOW_A && c <= CH_LOW_F)
        begin
            v = 4'(c - CH_LOW_A + 8'd10);
            return 1'b1;
        end
        if (c >= CH_UP_A && c <= CH_UP_F)
        begin
            v = 4'(c - CH_UP_A + 8'd10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit is_cut(input logic [7:0] c);
        return (c == CH_SEMI) || (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    // Start a fresh size line; the whole-body reset also clears the error.
    function automatic void open_size_line();
        dec_phase  = PH_SIZE;
        size_acc   = '0;
        digit_seen = 1'b0;
        in_ext     = 1'b0;
        cr_pend    = 1'b0;
    endfunction

    function automatic void clear_decoder();
        open_size_line();
        data_left = '0;
        skip_left = 2'd0;
        err_code  = ERR_NONE;
    endfunction

    function automatic void enter_error(input logic [1:0] code);
        err_code  = code;
        dec_phase = PH_ERR;
    endfunction

    // Advance the decoder by one body byte and return the result it owes.
    function automatic result_t decode_byte(input logic [7:0] c, input logic start);
        result_t    r;
        logic [3:0] nib;
        bit         handled;
        r       = '0;
        handled = 1'b0;
        if (start)
            clear_decoder();
        case (dec_phase)
            PH_SIZE:
            begin
                if (cr_pend)
                begin
                    cr_pend = 1'b0;
                    if (c == CH_LF)
                    begin
                        // CR LF closes the line
                        handled = 1'b1;
                        if (!digit_seen)
                            enter_error(ERR_EMPTY);
                        else if (size_acc == '0)
                            dec_phase = PH_DONE;
                        else
                        begin
                            data_left = size_acc;
                            dec_phase = PH_DATA;
                        end
                    end
                    else if (!in_ext)
                    begin
                        // lone CR among the digits; drop this byte unseen
                        handled = 1'b1;
                        enter_error(ERR_HEX);
                    end
                end
                if (!handled)
                begin
                    if (c == CH_CR)
                        cr_pend = 1'b1;
                    else if (!in_ext)
                    begin
                        if (is_cut(c))
                            in_ext = 1'b1;
                        else if (!hex_nibble(c, nib))
                            enter_error(ERR_HEX);
                        else if (size_acc[SIZE_W-1 -: 4] != 4'd0)
                            enter_error(ERR_OVF);
                        else
                        begin
                            size_acc   = {size_acc[SIZE_W-5:0], nib};
                            digit_seen = 1'b1;
                        end
                    end
                end
            end
            PH_DATA:
            begin
                r.payload_byte  = c;
                r.payload_valid = 1'b1;
                data_left       = data_left - 1'b1;
                if (data_left == '0)
                begin
                    r.chunk_last = 1'b1;
                    dec_phase    = PH_SKIP;
                    skip_left    = SKIP_LEN;
                end
            end
            PH_SKIP:
            begin
                skip_left = skip_left - 1'b1;
                if (skip_left == 2'd0)
                    open_size_line();
            end
            default:
            begin
            end
        endcase
        r.body_done    = (dec_phase == PH_DONE);
        r.decode_error = err_code;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------

    task automatic queue_byte(input logic [7:0] b);
        body_stream_q.push_back('{raw: b, start: next_start});
        next_start = 1'b0;
        items_queued++;
    endtask

    // Bytes after an end or an error: the block only passes its sticky state
    task automatic queue_junk(input int n);
        repeat (n)
        begin
            queue_byte(8'($urandom_range(255)));
            junk_queued++;
        end
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return 8'(CH_ZERO + n);
        return 8'(($urandom_range(1) ? CH_UP_A : CH_LOW_A) + n - 4'd10);
    endfunction

    // Emit the low ndig nibbles of v, most significant first
    task automatic queue_hex(input logic [63:0] v, input int ndig);
        for (int i = ndig - 1; i >= 0; i--)
            queue_byte(hex_char(v[4*i +: 4]));
    endtask

    function automatic logic [7:0] cut_char();
        case ($urandom_range(2))
            0:       return CH_SEMI;
            1:       return CH_SPACE;
            default: return CH_TAB;
        endcase
    endfunction

    function automatic logic [7:0] bad_char();
        logic [7:0] b;
        logic [3:0] nib;
        if ($urandom_range(3) == 0)
            return CH_LF;
        do
            b = 8'($urandom_range(255));
        while (hex_nibble(b, nib) || is_cut(b) || b == CH_CR);
        return b;
    endfunction

    // Cut character plus a random extension; a lone CR inside it is harmless
    task automatic queue_extension();
        logic [7:0] b;
        queue_byte(cut_char());
        repeat ($urandom_range(0, 5))
        begin
            if ($urandom_range(7) == 0)
            begin
                queue_byte(CH_CR);
                do
                    b = 8'($urandom_range(255));
                while (b == CH_LF || b == CH_CR);
                queue_byte(b);
            end
            else
            begin
                do
                    b = 8'($urandom_range(255));
                while (b == CH_CR);
                queue_byte(b);
            end
        end
    endtask

    task automatic queue_crlf();
        queue_byte(CH_CR);
        queue_byte(CH_LF);
    endtask

    task automatic queue_size_line(input logic [SIZE_W-1:0] size);
        int ndig;
        int pad;
        ndig = 1;
        while (ndig < SIZE_W / HEX_BITS && (size >> (HEX_BITS * ndig)) != '0)
            ndig++;
        pad = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
        queue_hex(64'(size), ndig + pad);
        if ($urandom_range(9) < 3)
            queue_extension();
        queue_crlf();
    endtask

    // Data bytes and the two trailing bytes the block drops unchecked
    task automatic queue_chunk(input int size);
        queue_size_line(SIZE_W'(size));
        repeat (size)
            queue_byte(8'($urandom_range(255)));
        if ($urandom_range(4) == 0)
        begin
            queue_byte(8'($urandom_range(255)));
            queue_byte(8'($urandom_range(255)));
        end
        else
            queue_crlf();
    endtask

    task automatic queue_good_body();
        next_start = 1'b1;
        repeat ($urandom_range(1, 4))
            queue_chunk(($urandom_range(9) == 0) ? $urandom_range(17, 64)
                                                 : $urandom_range(1, 16));
        queue_size_line('0);
        queue_junk($urandom_range(0, 3));
    endtask

    task automatic queue_broken_body();
        logic [7:0] b;
        int         kind;
        kind       = $urandom_range(5);
        next_start = 1'b1;
        if (kind == 5)
        begin
            // good first chunk, broken second line
            queue_chunk($urandom_range(1, 8));
            kind = 0;
        end
        case (kind)
            0:
            begin
                queue_hex(64'($urandom), $urandom_range(0, 3));
                queue_byte(bad_char());
            end
            1:
            begin
                if ($urandom_range(1))
                    queue_extension();
                queue_crlf();
            end
            2:
            begin
                // nonzero lead digit followed by eight more overflows the size
                queue_byte(hex_char(4'($urandom_range(1, 15))));
                queue_hex(64'($urandom), 8);
            end
            3:
            begin
                queue_hex(64'($urandom), $urandom_range(1, 3));
                queue_byte(CH_CR);
                do
                    b = 8'($urandom_range(255));
                while (b == CH_LF);
                queue_byte(b);
            end
            default:
            begin
                // huge chunk cut short by the next body start
                queue_size_line(SIZE_W'($urandom) | SIZE_W'(256));
                repeat ($urandom_range(1, 6))
                    queue_byte(8'($urandom_range(255)));
            end
        endcase
        if (kind != 4)
            queue_junk($urandom_range(0, 3));
    endtask

    task automatic queue_noise();
        repeat ($urandom_range(1, 8))
        begin
            next_start = ($urandom_range(9) == 0);
            queue_byte(8'($urandom_range(255)));
        end
    endtask

    // Hold the sender until every queued byte has come back as a result
    task automatic wait_drained();
        while (results_checked < items_queued)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Clock, driver, receiver stall, monitor, checker
    // ------------------------------------------------------------------

    initial
    begin
        forever
            #2 clk = ~clk;
    end

    // Present one byte per transfer; hold it steady while stalled and only
    // pick the next one once the line is free.
    always @(posedge clk or negedge rst_n)
    begin
        body_xfer_t nxt;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            body_byte  <= 8'h00;
            body_start <= 1'b0;
            cyc_cnt    <= '0;
        end
        else
        begin
            cyc_cnt <= cyc_cnt + 1'b1;
            if (in_valid && !in_stall)
                taken_bytes_q.push_back('{raw: body_byte, start: body_start});
            if (!in_valid || !in_stall)
            begin
                if (body_stream_q.size() > 0 &&
                    (calm || $urandom_range(99) >= src_idle_pct))
                begin
                    nxt = body_stream_q.pop_front();
                    in_valid   <= 1'b1;
                    body_byte  <= nxt.raw;
                    body_start <= nxt.start;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure; the calm window gives stretches with no stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= !calm && ($urandom_range(99) < snk_stall_pct);
    end

    // Capture each result transfer exactly at the edge where it happens
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            seen_out_q.push_back({payload_byte, payload_valid, chunk_last,
                                  body_done, decode_error});
    end

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
        end
    endtask

    // Work off everything captured at the last rising edge: decode the taken
    // bytes first, then match results against the oldest owed result.
    always @(negedge clk)
    begin
        body_xfer_t x;
        result_t    want;
        result_t    got;
        while (taken_bytes_q.size() > 0)
        begin
            x = taken_bytes_q.pop_front();
            decoded_q.push_back(decode_byte(x.raw, x.start));
        end
        while (seen_out_q.size() > 0)
        begin
            got = seen_out_q.pop_front();
            if (decoded_q.size() == 0)
            begin
                fail_cnt++;
                if (fail_cnt <= MAX_REPORTS)
                    $display("%0t: result with none expected, expected nothing, actual %0h",
                             $time, got);
            end
            else
            begin
                want = decoded_q.pop_front();
                check_field("payload_byte", want.payload_byte, got.payload_byte);
                check_field("payload_valid", 8'(want.payload_valid),
                            8'(got.payload_valid));
                check_field("chunk_last", 8'(want.chunk_last), 8'(got.chunk_last));
                check_field("body_done", 8'(want.body_done), 8'(got.body_done));
                check_field("decode_error", 8'(want.decode_error),
                            8'(got.decode_error));
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin
        int base;
        int goal;
        clear_decoder();
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: one tiny full body with an extension and a 0xFF data byte
        next_start = 1'b1;
        queue_byte(hex_char(4'd1));
        queue_byte(CH_SEMI);
        queue_crlf();
        queue_byte(8'hFF);
        queue_crlf();
        queue_byte(CH_ZERO);
        queue_crlf();
        queue_byte(8'h00);              // after the end: ignored, done stays up
        // bad hex character
        next_start = 1'b1;
        queue_byte(8'h67);
        // empty size line
        next_start = 1'b1;
        queue_crlf();
        // bare LF before any digit
        next_start = 1'b1;
        queue_byte(CH_LF);
        // lone CR among the digits
        next_start = 1'b1;
        queue_byte(hex_char(4'd1));
        queue_byte(CH_CR);
        queue_byte(8'h78);
        // size overflow on the ninth digit
        next_start = 1'b1;
        queue_byte(hex_char(4'd1));
        queue_hex(64'd0, 8);
        wait_drained();

        // Random bodies, one idling mix per phase; drain between phases
        base = items_queued - junk_queued;
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            case (ph)
                0:
                begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct  = 56;
                    snk_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 56;
                end
                default:
                begin
                    src_idle_pct  = 33;
                    snk_stall_pct = 33;
                end
            endcase
            goal = (RANDOM_GOAL * (ph + 1)) / PHASE_COUNT;
            while (items_queued - junk_queued - base < goal)
            begin
                case ($urandom_range(19))
                    0, 1, 2:  queue_broken_body();
                    3:        queue_noise();
                    default:  queue_good_body();
                endcase
            end
            wait_drained();
        end

        // Let any stray late result show up before the verdict
        repeat (DRAIN_CYCLES)
            @(negedge clk);
        if (fail_cnt == 0 && decoded_q.size() == 0 && seen_out_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #800000;
        $display("Some tests failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/chd_pkg.sv
rtl/core/chd_parser.sv
rtl/core/chd_out_stage.sv
rtl/core/http_chunked_body_decoder_top.sv
rtl/core/chd_checker.sv
sim/http_chunked_body_decoder_top_tb.sv
